// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the TLB lookup/insert core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define TLBF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TLBF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/tlbf_pkg.sv -----
// ----------------------------------------------------------------------------
// tlbf_pkg
// Shared constants and controller/datapath link types for the TLB core.
// ----------------------------------------------------------------------------
package tlbf_pkg;

  localparam int unsigned TLBF_ENTRIES    = 16;
  localparam int unsigned TLBF_VPAGE_W    = 20;
  localparam int unsigned TLBF_PAGE_SHIFT = 12;
  localparam int unsigned TLBF_PPAGE_W    = 18;
  localparam int unsigned TLBF_PADDR_W    = TLBF_PPAGE_W + TLBF_PAGE_SHIFT;
  localparam int unsigned TLBF_SLOT_W     = 4;
  localparam int unsigned TLBF_CNT_W      = 32;

  // Beat widths, packed fields padded up to whole bytes.
  localparam int unsigned TLBF_S_FIELDS_W = TLBF_VPAGE_W + TLBF_PAGE_SHIFT + TLBF_PPAGE_W;
  localparam int unsigned TLBF_S_TDATA_W  = ((TLBF_S_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned TLBF_M_FIELDS_W = TLBF_PADDR_W + TLBF_SLOT_W + 2 * TLBF_CNT_W;
  localparam int unsigned TLBF_M_TDATA_W  = ((TLBF_M_FIELDS_W + 7) / 8) * 8;

  // Command codes carried in the input tuser bit.
  localparam logic TLBF_CMD_LOOKUP = 1'b0;
  localparam logic TLBF_CMD_INSERT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the incoming item
    logic exec;   // run the captured item and load the result register
  } tlbf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } tlbf_sts_t;

endpackage

// ----- design/tlbf_ctrl.sv -----
// ----------------------------------------------------------------------------
// tlbf_ctrl
// Two-state controller: capture an item, then execute it once the result
// register has room.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlbf_ctrl
  import tlbf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  tlbf_sts_t sts_i,
  output tlbf_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o.load = in_valid_i && in_ready_o;
  assign cmd_o.exec = (state_q == S_EXEC) && sts_i.out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.load) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // An accepted item must be executed next, never dropped back to idle.
  `TLBF_ASSERT(a_load_to_exec, clk_i, rst_ni, cmd_o.load |=> (state_q == S_EXEC), "load did not enter execute")
  // A stalled item stays in execute until the result register frees up.
  `TLBF_ASSERT(a_exec_holds, clk_i, rst_ni, ((state_q == S_EXEC) && !sts_i.out_free) |=> (state_q == S_EXEC), "stalled item lost")

endmodule

// ----- design/tlbf_datapath.sv -----
// ----------------------------------------------------------------------------
// tlbf_datapath
// Item register, entry store with parallel tag compare, replacement pointer,
// counters and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlbf_datapath
  import tlbf_pkg::*;
#(
  parameter int unsigned ENTRIES = TLBF_ENTRIES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tlbf_cmd_t                  cmd_i,
  output tlbf_sts_t                  sts_o,
  input  logic                       in_cmd_i,
  input  logic [TLBF_VPAGE_W-1:0]    in_vpage_i,
  input  logic [TLBF_PAGE_SHIFT-1:0] in_offset_i,
  input  logic [TLBF_PPAGE_W-1:0]    in_ppage_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic                       out_hit_o,
  output logic [TLBF_PADDR_W-1:0]    out_paddr_o,
  output logic [TLBF_SLOT_W-1:0]     out_slot_o,
  output logic [TLBF_CNT_W-1:0]      out_access_o,
  output logic [TLBF_CNT_W-1:0]      out_miss_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);

  // Captured item.
  logic                       item_cmd_q;
  logic [TLBF_VPAGE_W-1:0]    item_vpage_q;
  logic [TLBF_PAGE_SHIFT-1:0] item_offset_q;
  logic [TLBF_PPAGE_W-1:0]    item_ppage_q;

  // Entry store.
  logic [ENTRIES-1:0]      valid_q, valid_d;
  logic [TLBF_VPAGE_W-1:0] tag_q   [ENTRIES];
  logic [TLBF_PPAGE_W-1:0] frame_q [ENTRIES];
  logic [IdxW-1:0]         victim_q, victim_d;
  logic [TLBF_CNT_W-1:0]   lookup_cnt_q, lookup_cnt_d;
  logic [TLBF_CNT_W-1:0]   miss_cnt_q, miss_cnt_d;

  // Search results.
  logic [ENTRIES-1:0]      match, match_oh, free, free_oh, victim_oh, wr_oh, wr_en;
  logic                    hit, any_free, is_lookup, is_insert;
  logic [IdxW-1:0]         hit_idx, free_idx, wr_idx, slot_idx;
  logic [TLBF_PPAGE_W-1:0] frame_sel;
  logic [TLBF_SLOT_W+IdxW-1:0] slot_wide;

  // Result register.
  logic                    out_valid_q, out_valid_d;
  logic                    out_hit_q;
  logic [TLBF_PADDR_W-1:0] out_paddr_q;
  logic [TLBF_SLOT_W-1:0]  out_slot_q;
  logic [TLBF_CNT_W-1:0]   out_access_q, out_miss_q;

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_cmd_q    <= in_cmd_i;
      item_vpage_q  <= in_vpage_i;
      item_offset_q <= in_offset_i;
      item_ppage_q  <= in_ppage_i;
    end
  end

  assign is_lookup = cmd_i.exec && (item_cmd_q == TLBF_CMD_LOOKUP);
  assign is_insert = cmd_i.exec && (item_cmd_q == TLBF_CMD_INSERT);

  // Compare every entry at once, then isolate the lowest set bit.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]     = valid_q[i] && (tag_q[i] == item_vpage_q);
      victim_oh[i] = (victim_q == IdxW'(i));
    end
  end

  assign free     = ~valid_q;
  assign match_oh = match & (~match + ENTRIES'(1));
  assign free_oh  = free & (~free + ENTRIES'(1));
  assign hit      = |match;
  assign any_free = |free;

  always_comb begin
    hit_idx   = '0;
    free_idx  = '0;
    frame_sel = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_oh[i]) begin
        hit_idx = hit_idx | IdxW'(i);
      end
      if (free_oh[i]) begin
        free_idx = free_idx | IdxW'(i);
      end
      frame_sel = frame_sel | ({TLBF_PPAGE_W{match_oh[i]}} & frame_q[i]);
    end
  end

  // Inserts fill the lowest empty slot, else the round-robin victim.
  assign wr_oh  = any_free ? free_oh : victim_oh;
  assign wr_idx = any_free ? free_idx : victim_q;
  assign wr_en  = {ENTRIES{is_insert}} & wr_oh;

  assign valid_d = valid_q | wr_en;

  always_comb begin
    victim_d = victim_q;
    if (is_insert && !any_free) begin
      victim_d = (victim_q == IdxW'(ENTRIES - 1)) ? '0 : victim_q + IdxW'(1);
    end
  end

  assign lookup_cnt_d = is_lookup ? lookup_cnt_q + TLBF_CNT_W'(1) : lookup_cnt_q;
  assign miss_cnt_d   = (is_lookup && !hit) ? miss_cnt_q + TLBF_CNT_W'(1) : miss_cnt_q;

  // Slot number reported is the low bits of the entry index.
  assign slot_idx  = is_lookup ? (hit ? hit_idx : '0) : wr_idx;
  assign slot_wide = {TLBF_SLOT_W'(0), slot_idx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      victim_q     <= '0;
      lookup_cnt_q <= '0;
      miss_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      valid_q      <= valid_d;
      victim_q     <= victim_d;
      lookup_cnt_q <= lookup_cnt_d;
      miss_cnt_q   <= miss_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (wr_en[i]) begin
        tag_q[i]   <= item_vpage_q;
        frame_q[i] <= item_ppage_q;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_hit_q    <= is_lookup && hit;
      out_paddr_q  <= (is_lookup && hit) ? {frame_sel, item_offset_q} : '0;
      out_slot_q   <= slot_wide[TLBF_SLOT_W-1:0];
      out_access_q <= lookup_cnt_d;
      out_miss_q   <= miss_cnt_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_hit_o    = out_hit_q;
  assign out_paddr_o  = out_paddr_q;
  assign out_slot_o   = out_slot_q;
  assign out_access_o = out_access_q;
  assign out_miss_o   = out_miss_q;

  // The round-robin pointer never names a slot beyond the store.
  `TLBF_ASSERT(a_victim_range, clk_i, rst_ni, (victim_q <= IdxW'(ENTRIES - 1)), "victim pointer out of range")
  // A result is only loaded when the previous one is gone or leaving.
  `TLBF_ASSERT(a_no_overwrite, clk_i, rst_ni, cmd_i.exec |-> (!out_valid_q || out_ready_i), "result overwritten")
  // Inserts leave both counters alone.
  `TLBF_ASSERT(a_insert_counts, clk_i, rst_ni, is_insert |=> ($stable(lookup_cnt_q) && $stable(miss_cnt_q)), "insert changed counters")

endmodule

// ----- design/tlb_lookup_insert_fifo_core.sv -----
// ----------------------------------------------------------------------------
// tlb_lookup_insert_fifo_core
// Fully associative TLB with round-robin replacement and access/miss counters.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Beat contents
//   s_axis   in   tuser: cmd (0 lookup, 1 insert); tdata: virt_page, page_offset,
//                 phys_page
//   m_axis   out  tuser: hit; tdata: xlat_addr, slot_used, access_total,
//                 miss_total
//
// Each item is first captured from the beat, then executed: all tags
// are compared in parallel and the entry store, pointer and counters update.
// That single compare-and-update pass through the entry store sets the rate.
// The result sits in an output register, so the next beat is accepted while
// the previous result still waits; a stalled output holds an item in execute.
// Reset clears the valid bits, the replacement pointer and both counters.
//
module tlb_lookup_insert_fifo_core
  import tlbf_pkg::*;
#(
  parameter int unsigned ENTRIES = TLBF_ENTRIES
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // [19:0] virt_page, [31:20] page_offset, [49:32] phys_page, [55:50] zero
  input  logic [TLBF_S_TDATA_W-1:0] s_axis_tdata,
  // [0] cmd
  input  logic                      s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [29:0] xlat_addr, [33:30] slot_used, [65:34] access_total,
  // [97:66] miss_total, [103:98] zero
  output logic [TLBF_M_TDATA_W-1:0] m_axis_tdata,
  // [0] hit
  output logic                      m_axis_tuser
);

  localparam int unsigned OffLo  = TLBF_VPAGE_W;
  localparam int unsigned PpgLo  = OffLo + TLBF_PAGE_SHIFT;
  localparam int unsigned PadW   = TLBF_M_TDATA_W - TLBF_M_FIELDS_W;

  tlbf_cmd_t cmd;
  tlbf_sts_t sts;

  logic [TLBF_PADDR_W-1:0] out_paddr;
  logic [TLBF_SLOT_W-1:0]  out_slot;
  logic [TLBF_CNT_W-1:0]   out_access, out_miss;

  tlbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tlbf_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_cmd_i     (s_axis_tuser),
    .in_vpage_i   (s_axis_tdata[TLBF_VPAGE_W-1:0]),
    .in_offset_i  (s_axis_tdata[PpgLo-1:OffLo]),
    .in_ppage_i   (s_axis_tdata[PpgLo+TLBF_PPAGE_W-1:PpgLo]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_hit_o    (m_axis_tuser),
    .out_paddr_o  (out_paddr),
    .out_slot_o   (out_slot),
    .out_access_o (out_access),
    .out_miss_o   (out_miss)
  );

  // Result fields packed from the lowest bit up, zero padded to bytes.
  assign m_axis_tdata = {PadW'(0), out_miss, out_access, out_slot, out_paddr};

endmodule
